@@ rtl/ert_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and helpers for the endpoint registry table.
// No dependencies.
package ert_pkg;

	// Number of table rows (1 to 127).
	localparam int Rows = 8;
	// Row number width; at least one bit.
	localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
	localparam int EpW = 8;
	localparam int IdxOutW = 3;

	typedef logic [RowW-1:0] row_t;
	typedef logic [EpW-1:0] ep_t;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXISTS    = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Low three bits of a row number, zero-extended for small tables.
	function automatic logic [IdxOutW-1:0] to_row_index(input row_t r);
		logic [7:0] w;
		w = 8'(r);
		return w[IdxOutW-1:0];
	endfunction

endpackage

@@ rtl/endpoint_registry_table_top.sv @@
`timescale 1ns / 1ps
// Endpoint registry table: top level with row memory, scan sequencer and result register.
// Depends on ert_pkg.
//
// Usage:
//  - Command channel: drive op and endpoint_id with start high; the item is taken
//    at a rising edge where start is high and busy is low. busy stays high while
//    the item is being worked on.
//  - Result channel: done is high for exactly one cycle with status and row_index
//    valid. There is no backpressure; the receiver must take it that cycle.
//  - Each item scans every row of the endpoint memory, one read per cycle, through
//    the single synchronous read port. The scan is followed by a drain state and a
//    resolve state, and done is raised from the resolve state.
//    The next item may be accepted at the edge that ends the cycle done is shown;
//    no new item is taken while the previous one is still being worked on.
//  - The resolve cycle writes the endpoint memory and the valid bits; no read is
//    in flight then, so no forwarding is needed.
//  - Reset (arst_n low) clears all valid bits at once; the endpoint memory is not
//    cleared, since an entry is only compared while its row is valid.
//  - Unused op code: the table is left alone and the result is not found, row 0.
module endpoint_registry_table_top
	import ert_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   op,
	input  logic [7:0]   endpoint_id,
	output logic         busy,
	output logic         done,
	output logic [1:0]   status,
	output logic [2:0]   row_index
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESOLVE
	} state_t;

	state_t state_q;

	// Endpoint storage, one synchronous read port.
	ep_t mem [Rows];
	ep_t rd_data_s1;
	row_t cmp_idx_s1;
	logic cmp_v_s1;

	logic [Rows-1:0] row_valid_q;

	// Latched command.
	op_t op_q;
	ep_t ep_q;

	// Scan address.
	row_t rd_addr_q;

	// Scan results: lowest matching row and lowest free row.
	logic hit_q;
	row_t hit_row_q;
	logic free_q;
	row_t free_row_q;

	// Memory write, driven from the resolve cycle.
	logic wr_en;
	row_t wr_addr;

	logic last_addr;
	assign last_addr = (rd_addr_q == row_t'(Rows - 1));

	always_comb begin
		wr_en = 1'b0;
		wr_addr = free_row_q;
		if (state_q == S_RESOLVE && op_q == OP_ADD && !hit_q && free_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= ep_q;
		end
		rd_data_s1 <= mem[rd_addr_q];
		cmp_idx_s1 <= rd_addr_q;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			cmp_v_s1    <= 1'b0;
			rd_addr_q   <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			hit_row_q   <= '0;
			free_row_q  <= '0;
			op_q        <= OP_NONE;
			ep_q        <= '0;
			done        <= 1'b0;
			status      <= ST_NOT_FOUND;
			row_index   <= '0;
		end else begin
			done     <= 1'b0;
			cmp_v_s1 <= (state_q == S_SCAN);

			// Compare the row read in the previous cycle.
			if (cmp_v_s1) begin
				if (row_valid_q[cmp_idx_s1]) begin
					if (rd_data_s1 == ep_q && !hit_q) begin
						hit_q     <= 1'b1;
						hit_row_q <= cmp_idx_s1;
					end
				end else if (!free_q) begin
					free_q     <= 1'b1;
					free_row_q <= cmp_idx_s1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= op_t'(op);
						ep_q      <= endpoint_id;
						rd_addr_q <= '0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (last_addr) begin
						state_q <= S_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + row_t'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_RESOLVE;
				end
				S_RESOLVE: begin
					done      <= 1'b1;
					status    <= ST_NOT_FOUND;
					row_index <= '0;
					case (op_q)
						OP_ADD: begin
							if (hit_q) begin
								status <= ST_EXISTS;
							end else if (!free_q) begin
								status <= ST_FULL;
							end else begin
								status                  <= ST_OK;
								row_index               <= to_row_index(free_row_q);
								row_valid_q[free_row_q] <= 1'b1;
							end
						end
						OP_REMOVE: begin
							if (hit_q) begin
								status                 <= ST_OK;
								row_index              <= to_row_index(hit_row_q);
								row_valid_q[hit_row_q] <= 1'b0;
							end
						end
						OP_LOOKUP: begin
							if (hit_q) begin
								status    <= ST_OK;
								row_index <= to_row_index(hit_row_q);
							end
						end
						default: begin
							status <= ST_NOT_FOUND;
						end
					endcase
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
